// ----- sv/rtt_heavy_flow_sketch_top_macros.svh -----
// Assertion macros used by the checker in sv/rhf_checker.sv.
`ifndef RTT_HEAVY_FLOW_SKETCH_TOP_MACROS_SVH
`define RTT_HEAVY_FLOW_SKETCH_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clock ck.
`define RHF_ASSERT_NOW(lbl, ck, dis, a, b) \
  lbl: assert property (@(posedge ck) disable iff (dis) (a) |-> (b)) \
    else $error("rhf assertion failed");

// Next-cycle implication, sampled on the rising edge of clock ck.
`define RHF_ASSERT_NEXT(lbl, ck, dis, a, b) \
  lbl: assert property (@(posedge ck) disable iff (dis) (a) |=> (b)) \
    else $error("rhf assertion failed");

`endif

// ----- sv/rhf_pkg.sv -----
package rhf_pkg;

  localparam int PENDING_DEPTH_DEF = 4096;
  localparam int FLOW_DEPTH_DEF = 1024;
  localparam int MAX_PROBES_DEF = 8;

  localparam logic [31:0] TIMEOUT_RST = 32'd1000000;
  localparam logic [3:0] PROBE_COUNT_RST = 4'd3;
  localparam logic [13:0] INDEX_SEED_RST = 14'd0;
  localparam logic [13:0] FP_SEED_RST = 14'd1;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_ADD = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

  localparam logic [15:0] FP_MOD = 16'hffff;

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_PROBES = 2'd1,
    CFG_INDEX_SEED = 2'd2,
    CFG_FP_SEED = 2'd3
  } cfg_index_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_ESTIMATE = 1'b1
  } func_t;

  typedef struct packed {
    logic func;
    logic [31:0] folded_key;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [31:0] timestamp;
    logic [9:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic [31:0] rtt_sample;
    logic [31:0] rtt_estimate;
    logic flow_found;
  } out_item_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } flow_id_t;

  typedef struct packed {
    flow_id_t id;
    logic [31:0] sum;
  } flow_entry_t;

  typedef struct packed {
    logic [15:0] fp;
    logic [31:0] seq;
    logic [31:0] stamp;
  } pend_entry_t;

  // Hash tag: fingerprint request, and first index probe (which also feeds the pending table).
  typedef struct packed {
    logic is_fp;
    logic first;
  } hash_tag_t;

endpackage

// ----- sv/rhf_ram.sv -----
module rhf_ram #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rhf_hash.sv -----
// Murmur3_x86_32 of one 32-bit word, five register stages, at most one multiply per stage.
module rhf_hash (
  input  logic clk,
  input  logic rst,
  input  logic in_v,
  input  rhf_pkg::hash_tag_t in_tag,
  input  logic [31:0] word,
  input  logic [31:0] seed,
  output logic out_v,
  output rhf_pkg::hash_tag_t out_tag,
  output logic [31:0] hash
);

  logic [4:0] v;
  rhf_pkg::hash_tag_t tag [5];
  logic [31:0] sd [2];
  logic [31:0] r1, r2, r3, r4, r5;
  logic [31:0] k2rot, h_a, h_b, h_c, r4x;

  always_comb begin
    k2rot = {r1[16:0], r1[31:17]};
    h_a = sd[1] ^ r2;
    h_b = {h_a[18:0], h_a[31:19]};
    h_c = ((h_b << 2) + h_b + rhf_pkg::MM_ADD) ^ 32'd4;
    r4x = r4 ^ (r4 >> 13);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:0], in_v};
    end
    tag[0] <= in_tag;
    for (int i = 1; i < 5; i++) begin
      tag[i] <= tag[i-1];
    end
    sd[0] <= seed;
    sd[1] <= sd[0];
    r1 <= word * rhf_pkg::MM_C1;
    r2 <= k2rot * rhf_pkg::MM_C2;
    r3 <= h_c ^ (h_c >> 16);
    r4 <= r3 * rhf_pkg::MM_F1;
    r5 <= r4x * rhf_pkg::MM_F2;
  end

  assign out_v = v[4];
  assign out_tag = tag[4];
  assign hash = r5 ^ (r5 >> 16);

endmodule

// ----- sv/rhf_mod.sv -----
// Remainder of a 32-bit value by a constant: reciprocal multiply, back-multiply, one correction.
module rhf_mod #(
  parameter int DIV = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic in_v,
  input  logic in_first,
  input  logic [31:0] value,
  output logic out_v,
  output logic out_first,
  output logic [$clog2(DIV)-1:0] rem
);

  localparam int AW = $clog2(DIV);
  localparam logic [63:0] RECIP64 = 64'h1_0000_0000 / DIV;
  localparam logic [31:0] RECIP = RECIP64[31:0];
  localparam logic [31:0] DIV32 = 32'(DIV);

  logic [2:0] v;
  logic [2:0] first;
  logic [31:0] val_q;
  logic [31:0] quot;
  logic [63:0] prod;
  logic [31:0] diff;
  logic [AW:0] part;

  assign prod = {32'd0, value} * {32'd0, RECIP};
  assign diff = val_q - quot * DIV32;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[1:0], in_v};
    end
    first <= {first[1:0], in_first};
    val_q <= value;
    quot <= prod[63:32];
    // The quotient estimate is low by at most one, so part stays below twice DIV.
    part <= diff[AW:0];
    if (part >= (AW+1)'(DIV)) begin
      rem <= AW'(part - (AW+1)'(DIV));
    end else begin
      rem <= part[AW-1:0];
    end
  end

  assign out_v = v[2];
  assign out_first = first[2];

endmodule

// ----- sv/rtt_heavy_flow_sketch_top.sv -----
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_data (rhf_pkg::in_item_t)
// out      output     out_valid/out_stall out_data (rhf_pkg::out_item_t)
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item at a time; with n being the probe count used, an item goes through
// n + 1 hash issues, then the five-stage hash, three-stage remainder and the memory read.
// After reset a clearing pass writes zero over max(PENDING_DEPTH, FLOW_DEPTH) entries,
// one per cycle, with in_stall high. A finished item waits in the output register
// while out_stall is high; the next item is taken meanwhile.
module rtt_heavy_flow_sketch_top #(
  parameter int PENDING_DEPTH = rhf_pkg::PENDING_DEPTH_DEF,
  parameter int FLOW_DEPTH = rhf_pkg::FLOW_DEPTH_DEF,
  parameter int MAX_PROBES = rhf_pkg::MAX_PROBES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  rhf_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rhf_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PAW = $clog2(PENDING_DEPTH);
  localparam int FAW = $clog2(FLOW_DEPTH);
  localparam int PW = $clog2(MAX_PROBES + 1);
  localparam int MAXD = (PENDING_DEPTH > FLOW_DEPTH) ? PENDING_DEPTH : FLOW_DEPTH;
  localparam int CLW = $clog2(MAXD);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ISSUE  = 6'b000100,
    ST_WAIT   = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  logic [CLW-1:0] clr_cnt;

  logic [31:0] timeout_ticks;
  logic [3:0] probe_count;
  logic [13:0] index_seed;
  logic [13:0] fingerprint_seed;

  rhf_pkg::in_item_t item;
  rhf_pkg::flow_id_t item_id;
  logic [PW-1:0] n_probes, issue_cnt, proc_cnt;
  logic [15:0] fp;

  // Hash and remainder stream.
  logic hin_v;
  rhf_pkg::hash_tag_t hin_tag;
  logic [31:0] hin_seed;
  logic hout_v;
  rhf_pkg::hash_tag_t hout_tag;
  logic [31:0] hout;
  logic pm_v, pm_first, fm_v, fm_first;
  logic [PAW-1:0] pm_slot;
  logic [FAW-1:0] fm_slot;

  // Memory ports.
  logic pend_we, flow_we;
  logic [PAW-1:0] pend_waddr;
  logic [FAW-1:0] flow_waddr;
  rhf_pkg::pend_entry_t pend_wdata, pend_rdata;
  rhf_pkg::flow_entry_t flow_wdata, flow_rdata;
  logic pd_v, fd_v;
  logic [PAW-1:0] pd_slot;
  logic [FAW-1:0] fd_slot;

  // Pending result.
  logic [31:0] sample;
  logic pend_take;
  logic [PAW-1:0] pend_slot_q;
  logic [31:0] age;

  // Flow probe scan.
  logic found_q, empty_q, min_q, replace_q;
  logic [FAW-1:0] found_slot, empty_slot, min_slot;
  logic [31:0] found_sum, min_val;
  rhf_pkg::flow_id_t min_id;
  logic id_match;

  logic [16:0] fold_s, fold_r;
  logic [42:0] lhs, rhs;
  logic out_free, finish_go, is_insert, flow_upd;
  logic [PW-1:0] n_accept;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign finish_go = (state == ST_FINISH) && out_free;
  assign is_insert = (item.func == rhf_pkg::FUNC_INSERT);
  assign item_id = '{src: item.source_address, dst: item.dest_address,
                     sport: item.source_port, dport: item.dest_port};

  always_comb begin
    if (probe_count == 4'd0) begin
      n_accept = PW'(1);
    end else if (int'(probe_count) > MAX_PROBES) begin
      n_accept = PW'(MAX_PROBES);
    end else begin
      n_accept = PW'(probe_count);
    end
  end

  // Issue the fingerprint hash first, then one index hash per probe.
  assign hin_v = (state == ST_ISSUE);
  assign hin_tag = '{is_fp: (issue_cnt == '0), first: (issue_cnt == PW'(1))};
  assign hin_seed = (issue_cnt == '0) ? 32'(fingerprint_seed) :
                    32'(index_seed) + 32'(issue_cnt) - 32'd1;

  rhf_hash u_hash (
    .clk(clk), .rst(rst), .in_v(hin_v), .in_tag(hin_tag), .word(item.folded_key),
    .seed(hin_seed), .out_v(hout_v), .out_tag(hout_tag), .hash(hout)
  );

  rhf_mod #(.DIV(PENDING_DEPTH)) u_pmod (
    .clk(clk), .rst(rst), .in_v(hout_v && !hout_tag.is_fp && hout_tag.first),
    .in_first(hout_tag.first), .value(hout), .out_v(pm_v), .out_first(pm_first),
    .rem(pm_slot)
  );

  rhf_mod #(.DIV(FLOW_DEPTH)) u_fmod (
    .clk(clk), .rst(rst), .in_v(hout_v && !hout_tag.is_fp),
    .in_first(hout_tag.first), .value(hout), .out_v(fm_v), .out_first(fm_first),
    .rem(fm_slot)
  );

  // Fingerprint: hash mod 65535 by folding the two halves.
  assign fold_s = {1'b0, hout[31:16]} + {1'b0, hout[15:0]};
  assign fold_r = (fold_s >= {1'b0, rhf_pkg::FP_MOD}) ? fold_s - {1'b0, rhf_pkg::FP_MOD} :
                  fold_s;

  assign age = item.timestamp - pend_rdata.stamp;
  assign id_match = (flow_rdata.id == item_id);

  assign lhs = 43'(item.random_draw) * (43'(sample) + 43'(min_val));
  assign rhs = 43'(sample) * 43'd1000;

  assign flow_upd = is_insert && (sample != 32'd0) && (found_q || empty_q || min_q);

  // Memory write ports: clearing pass, or the write-back at the end of an item.
  always_comb begin
    pend_we = 1'b0;
    pend_waddr = clr_cnt[PAW-1:0];
    pend_wdata = '0;
    flow_we = 1'b0;
    flow_waddr = clr_cnt[FAW-1:0];
    flow_wdata = '0;
    if (state == ST_CLEAR) begin
      pend_we = (int'(clr_cnt) < PENDING_DEPTH);
      flow_we = (int'(clr_cnt) < FLOW_DEPTH);
    end else if (finish_go) begin
      pend_we = is_insert && pend_take;
      pend_waddr = pend_slot_q;
      pend_wdata = '{fp: fp, seq: item.ack_number, stamp: item.timestamp};
      flow_we = flow_upd;
      if (found_q) begin
        flow_waddr = found_slot;
        flow_wdata = '{id: item_id, sum: found_sum + sample};
      end else if (empty_q) begin
        flow_waddr = empty_slot;
        flow_wdata = '{id: item_id, sum: sample};
      end else begin
        flow_waddr = min_slot;
        flow_wdata = '{id: (replace_q ? item_id : min_id), sum: min_val + sample};
      end
    end
  end

  rhf_ram #(.W($bits(rhf_pkg::pend_entry_t)), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pm_slot), .rdata(pend_rdata)
  );

  rhf_ram #(.W($bits(rhf_pkg::flow_entry_t)), .DEPTH(FLOW_DEPTH)) u_flow_ram (
    .clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
    .raddr(fm_slot), .rdata(flow_rdata)
  );

  always_ff @(posedge clk) begin
    pd_slot <= pm_slot;
    fd_slot <= fm_slot;
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      pd_v <= 1'b0;
      fd_v <= 1'b0;
      timeout_ticks <= rhf_pkg::TIMEOUT_RST;
      probe_count <= rhf_pkg::PROBE_COUNT_RST;
      index_seed <= rhf_pkg::INDEX_SEED_RST;
      fingerprint_seed <= rhf_pkg::FP_SEED_RST;
    end else begin
      pd_v <= pm_v && pm_first;
      fd_v <= fm_v;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rhf_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data;
          rhf_pkg::CFG_PROBES: probe_count <= cfg_data[3:0];
          rhf_pkg::CFG_INDEX_SEED: index_seed <= cfg_data[13:0];
          rhf_pkg::CFG_FP_SEED: fingerprint_seed <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && !finish_go) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CLW'(1);
          if (clr_cnt == CLW'(MAXD - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            n_probes <= n_accept;
            issue_cnt <= '0;
            proc_cnt <= '0;
            found_q <= 1'b0;
            empty_q <= 1'b0;
            min_q <= 1'b0;
            sample <= '0;
            pend_take <= 1'b0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          issue_cnt <= issue_cnt + PW'(1);
          if (issue_cnt == n_probes) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (proc_cnt == n_probes) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          replace_q <= (lhs <= rhs);
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data.rtt_sample <= is_insert ? sample : 32'd0;
            out_data.rtt_estimate <= is_insert ? 32'd0 : (found_q ? found_sum : 32'd1);
            out_data.flow_found <= is_insert ? (found_q && sample != 32'd0) : found_q;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase

      if (hout_v && hout_tag.is_fp) begin
        fp <= (fold_r == {1'b0, rhf_pkg::FP_MOD}) ? 16'd0 : fold_r[15:0];
      end

      // Pending entry of the first probe.
      if (pd_v) begin
        pend_slot_q <= pd_slot;
        if (fp == pend_rdata.fp) begin
          pend_take <= 1'b1;
          if (item.seq_number == pend_rdata.seq && age <= timeout_ticks && !age[31]) begin
            sample <= age;
          end
        end else if (pend_rdata.fp == 16'd0 || age > timeout_ticks) begin
          pend_take <= 1'b1;
        end
      end

      // Flow probes arrive in probe order; the first match ends the scan.
      if (fd_v) begin
        proc_cnt <= proc_cnt + PW'(1);
        if (!found_q) begin
          if (!is_insert) begin
            if (id_match) begin
              found_q <= 1'b1;
              found_sum <= flow_rdata.sum;
            end
          end else if (flow_rdata.id.src == 32'd0) begin
            empty_q <= 1'b1;
            empty_slot <= fd_slot;
          end else if (id_match) begin
            found_q <= 1'b1;
            found_slot <= fd_slot;
            found_sum <= flow_rdata.sum;
          end else if (!min_q || flow_rdata.sum < min_val) begin
            min_q <= 1'b1;
            min_slot <= fd_slot;
            min_val <= flow_rdata.sum;
            min_id <= flow_rdata.id;
          end
        end
      end
    end
  end

endmodule

// ----- sv/rhf_checker.sv -----
`include "rtt_heavy_flow_sketch_top_macros.svh"

module rhf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // Reset starts the clearing pass, which holds off input.
  `RHF_ASSERT_NEXT(a_reset_stalls, clk, 1'b0, rst, in_stall)
  // An accepted item keeps the input stalled while it is worked on.
  `RHF_ASSERT_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall)
  // A new result only appears when an item was in progress the cycle before.
  `RHF_ASSERT_NOW(a_result_from_item, clk, rst, $rose(out_valid), $past(in_stall))
  `RHF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

endmodule

bind rtt_heavy_flow_sketch_top rhf_checker u_rhf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall)
);

// ----- bench/rtt_heavy_flow_sketch_top_tb.sv -----
`timescale 1ns / 1ps

module rtt_heavy_flow_sketch_top_tb;

  localparam int PEND_N = rhf_pkg::PENDING_DEPTH_DEF;
  localparam int FLOW_N = rhf_pkg::FLOW_DEPTH_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 40;
  localparam int NUM_PHASES = 5;
  localparam int PHASE_ITEMS = 140;
  localparam int POOL_N = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rhf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rhf_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rtt_heavy_flow_sketch_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sketch state mirrored on the test side.
  logic [31:0] timeout_ticks = rhf_pkg::TIMEOUT_RST;
  logic [3:0] probe_count = rhf_pkg::PROBE_COUNT_RST;
  logic [13:0] index_seed = rhf_pkg::INDEX_SEED_RST;
  logic [13:0] fp_seed = rhf_pkg::FP_SEED_RST;
  logic [15:0] pend_fp [PEND_N];
  logic [31:0] pend_seq [PEND_N];
  logic [31:0] pend_stamp [PEND_N];
  rhf_pkg::flow_id_t flow_ids [FLOW_N];
  logic [31:0] flow_sums [FLOW_N];

  rhf_pkg::out_item_t rtt_expected [$];
  int errors = 0;
  int send_pct = 0;
  int recv_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int hold_seen = 0;
  int idle_cycles = 0;

  function automatic logic [31:0] murmur(input logic [31:0] w, input logic [31:0] s);
    logic [31:0] k, h;
    k = w * rhf_pkg::MM_C1;
    k = {k[16:0], k[31:17]} * rhf_pkg::MM_C2;
    h = s ^ k;
    h = {h[18:0], h[31:19]} * 32'd5 + rhf_pkg::MM_ADD;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * rhf_pkg::MM_F1;
    h = h ^ (h >> 13);
    h = h * rhf_pkg::MM_F2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  task automatic predict_rtt(input rhf_pkg::in_item_t it, output rhf_pkg::out_item_t r);
    rhf_pkg::flow_id_t id;
    int n, slot, pidx, empty_slot, min_slot;
    logic [31:0] fp, age, sample, min_val;
    logic [63:0] lhs, rhs;
    bit take, found, have_empty, have_min;
    id = '{it.source_address, it.dest_address, it.source_port, it.dest_port};
    n = (probe_count == 0) ? 1 :
        (probe_count > rhf_pkg::MAX_PROBES_DEF) ? rhf_pkg::MAX_PROBES_DEF : probe_count;
    r = '0;
    found = 0;
    if (it.func == rhf_pkg::FUNC_ESTIMATE) begin
      r.rtt_estimate = 32'd1;
      for (int i = 0; i < n && !found; i++) begin
        slot = murmur(it.folded_key, 32'(index_seed) + i) % FLOW_N;
        if (flow_ids[slot] == id) begin
          r.rtt_estimate = flow_sums[slot];
          found = 1;
        end
      end
    end else begin
      pidx = murmur(it.folded_key, 32'(index_seed)) % PEND_N;
      fp = murmur(it.folded_key, 32'(fp_seed)) % 32'd65535;
      age = it.timestamp - pend_stamp[pidx];
      sample = '0;
      take = 0;
      if (fp[15:0] == pend_fp[pidx]) begin
        if (it.seq_number == pend_seq[pidx] && age <= timeout_ticks && !age[31])
          sample = age;
        take = 1;
      end else if (pend_fp[pidx] == 0 || age > timeout_ticks) begin
        pend_fp[pidx] = fp[15:0];
        take = 1;
      end
      if (take) begin
        pend_seq[pidx] = it.ack_number;
        pend_stamp[pidx] = it.timestamp;
      end
      if (sample != 0) begin
        have_empty = 0;
        have_min = 0;
        empty_slot = 0;
        min_slot = 0;
        min_val = '0;
        for (int i = 0; i < n && !found; i++) begin
          slot = murmur(it.folded_key, 32'(index_seed) + i) % FLOW_N;
          if (flow_ids[slot].src == 0) begin
            have_empty = 1;
            empty_slot = slot;
          end else if (flow_ids[slot] == id) begin
            flow_sums[slot] += sample;
            found = 1;
          end else if (!have_min || flow_sums[slot] < min_val) begin
            have_min = 1;
            min_slot = slot;
            min_val = flow_sums[slot];
          end
        end
        if (!found) begin
          if (have_empty) begin
            flow_ids[empty_slot] = id;
            flow_sums[empty_slot] = sample;
          end else if (have_min) begin
            lhs = 64'(it.random_draw) * (64'(sample) + 64'(min_val));
            rhs = 64'd1000 * 64'(sample);
            flow_sums[min_slot] += sample;
            // The smallest entry changes owner only when the draw allows it.
            if (lhs <= rhs) flow_ids[min_slot] = id;
          end
        end
      end
      r.rtt_sample = sample;
    end
    r.flow_found = found;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    rhf_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (rtt_expected.size() == 0) begin
        report("unexpected item", out_data.rtt_sample, 32'd0);
      end else begin
        want = rtt_expected.pop_front();
        if (out_data.rtt_sample !== want.rtt_sample)
          report("rtt_sample", out_data.rtt_sample, want.rtt_sample);
        if (out_data.rtt_estimate !== want.rtt_estimate)
          report("rtt_estimate", out_data.rtt_estimate, want.rtt_estimate);
        if (out_data.flow_found !== want.flow_found)
          report("flow_found", 32'(out_data.flow_found), 32'(want.flow_found));
      end
    end
  end

  // Receiver stalls, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("rtt_heavy_flow_sketch_top: mismatch");
      $finish;
    end
  end

  task automatic offer(input rhf_pkg::in_item_t it, input bit typed,
                       input rhf_pkg::out_item_t want);
    rhf_pkg::out_item_t pred;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_rtt(it, pred);
    rtt_expected.insert(rtt_expected.size(), typed ? want : pred);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (rtt_expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_regs(input logic [31:0] t, input logic [3:0] p,
                            input logic [13:0] is, input logic [13:0] fs);
    logic [31:0] vals [4];
    rhf_pkg::cfg_index_t idx [4];
    vals = '{t, 32'(p), 32'(is), 32'(fs)};
    idx = '{rhf_pkg::CFG_TIMEOUT, rhf_pkg::CFG_PROBES, rhf_pkg::CFG_INDEX_SEED,
            rhf_pkg::CFG_FP_SEED};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        rhf_pkg::CFG_TIMEOUT: timeout_ticks = vals[i];
        rhf_pkg::CFG_PROBES: probe_count = vals[i][3:0];
        rhf_pkg::CFG_INDEX_SEED: index_seed = vals[i][13:0];
        default: fp_seed = vals[i][13:0];
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic rhf_pkg::in_item_t mk(input rhf_pkg::func_t f, input logic [31:0] key,
      input logic [31:0] src, input logic [31:0] dst, input logic [15:0] sp,
      input logic [15:0] dp, input logic [31:0] seq, input logic [31:0] ack,
      input logic [31:0] ts, input logic [9:0] draw);
    return '{f, key, src, dst, sp, dp, seq, ack, ts, draw};
  endfunction

  typedef struct {
    rhf_pkg::in_item_t it;
    bit typed;
    rhf_pkg::out_item_t want;
  } stim_row_t;

  rhf_pkg::in_item_t pool [POOL_N];
  logic [31:0] pool_key [8];
  logic [31:0] tick = 0;

  initial begin
    stim_row_t rows [$];
    rhf_pkg::in_item_t it;
    logic [31:0] t_arr [NUM_PHASES];
    logic [3:0] p_arr [NUM_PHASES];
    logic [13:0] is_arr [NUM_PHASES];
    logic [13:0] fs_arr [NUM_PHASES];
    logic [31:0] ack, delta;
    int f, roll;

    foreach (pend_fp[i]) begin
      pend_fp[i] = 0; pend_seq[i] = 0; pend_stamp[i] = 0;
    end
    foreach (flow_ids[i]) begin
      flow_ids[i] = '0; flow_sums[i] = 0;
    end

    t_arr = '{32'd1000000, 32'd0, 32'hffffffff, 32'd300, 32'd1000000};
    p_arr = '{4'd3, 4'd0, 4'd8, 4'd15, 4'd1};
    is_arr = '{14'd0, 14'd9999, 14'd0, 14'd17, 14'd5};
    fs_arr = '{14'd1, 14'd0, 14'd9999, 14'd4242, 14'd7};

    // Keys are shared by several identities so that probes collide.
    foreach (pool_key[i]) pool_key[i] = $urandom;
    foreach (pool[i]) begin
      pool[i] = mk(rhf_pkg::FUNC_INSERT, pool_key[i % 8], $urandom | 32'd1, $urandom,
                   16'($urandom), 16'($urandom), '0, '0, '0, '0);
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed rows: lookups on an empty sketch, extremes, a clean sample pair,
    // a zero delta, a stale entry and the all-zero identity.
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_ESTIMATE, '1, '1, '1, '1, '1, '1, '1, '1,
                                  10'd1023), 1, '{32'd0, 32'd1, 1'b0}});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_ESTIMATE, '0, '0, '0, '0, '0, '0, '0, '0,
                                  10'd0), 1, '{32'd0, 32'd0, 1'b1}});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_INSERT, '1, '1, '1, '1, '1, '1, '1, '1,
                                  10'd1023), 0, '0});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_INSERT, '0, '0, '0, '0, '0, '0, '0, '0,
                                  10'd0), 0, '0});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_INSERT, 32'h1234, 32'h0a000001,
                                  32'h0a000002, 16'd80, 16'd5000, 32'd5, 32'd77, 32'd1000,
                                  10'd500), 0, '0});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_INSERT, 32'h1234, 32'h0a000001,
                                  32'h0a000002, 16'd80, 16'd5000, 32'd77, 32'd90, 32'd1100,
                                  10'd500), 0, '0});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_ESTIMATE, 32'h1234, 32'h0a000001,
                                  32'h0a000002, 16'd80, 16'd5000, 32'd0, 32'd0, 32'd0,
                                  10'd0), 0, '0});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_INSERT, 32'h1234, 32'h0a000001,
                                  32'h0a000002, 16'd80, 16'd5000, 32'd90, 32'd91, 32'd1100,
                                  10'd0), 0, '0});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_INSERT, 32'h1234, 32'h0b000001,
                                  32'h0a000002, 16'd81, 16'd5000, 32'd91, 32'd92,
                                  32'd3001100, 10'd999), 0, '0});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_INSERT, 32'h1234, 32'h0b000001,
                                  32'h0a000002, 16'd81, 16'd5000, 32'd92, 32'd93,
                                  32'h80003000, 10'd0), 0, '0});
    rows.insert(rows.size(), '{mk(rhf_pkg::FUNC_ESTIMATE, '0, '0, '0, '0, '0, '0, '0, '0,
                                  10'd0), 0, '0});

    foreach (rows[i]) offer(rows[i].it, rows[i].typed, rows[i].want);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_pct = (ph < 2) ? 24 : (ph < 4) ? 71 : 0;
      recv_pct = (ph < 2) ? 71 : (ph < 4) ? 24 : 0;
      write_regs(t_arr[ph], p_arr[ph], is_arr[ph], fs_arr[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == NUM_PHASES - 1 && n == 40) hold_req++;
        if (ph == NUM_PHASES - 1 && n == 120) begin
          in_valid <= 1'b0;
          while (rtt_expected.size() != 0) @(negedge clk);
        end
        roll = $urandom_range(0, 99);
        f = $urandom_range(0, POOL_N - 1);
        if (roll < 55) begin
          // A data packet followed by the packet that acknowledges it.
          ack = $urandom;
          it = pool[f];
          it.func = rhf_pkg::FUNC_INSERT;
          it.seq_number = $urandom;
          it.ack_number = ack;
          it.timestamp = tick;
          it.random_draw = 10'($urandom_range(0, 999));
          offer(it, 0, '0);
          delta = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 400) : $urandom;
          tick += delta;
          it.seq_number = ack;
          it.ack_number = $urandom;
          it.timestamp = tick;
          it.random_draw = 10'($urandom_range(0, 999));
          offer(it, 0, '0);
          tick += $urandom_range(0, 50);
        end else if (roll < 80) begin
          it = pool[f];
          it.func = rhf_pkg::FUNC_ESTIMATE;
          it.random_draw = 10'($urandom_range(0, 1023));
          offer(it, 0, '0);
        end else begin
          it = mk(rhf_pkg::func_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                  16'($urandom), 16'($urandom), $urandom, $urandom, $urandom,
                  10'($urandom_range(0, 1023)));
          offer(it, 0, '0);
        end
      end
      drain_results();
    end

    if (errors == 0)
      $display("rtt_heavy_flow_sketch_top: match");
    else
      $display("rtt_heavy_flow_sketch_top: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/rhf_pkg.sv
sv/rhf_ram.sv
sv/rhf_hash.sv
sv/rhf_mod.sv
sv/rtt_heavy_flow_sketch_top.sv
sv/rhf_checker.sv
bench/rtt_heavy_flow_sketch_top_tb.sv
